@@ src/histeq_pkg.sv @@
package histeq_pkg;

    // Histogram geometry
    localparam int GRAY_LEVELS = 256;
    localparam int COUNT_BITS  = 24;
    localparam int PIX_BITS    = 8;
    localparam int LEVEL_BITS  = $clog2(GRAY_LEVELS);

    // Running sum of all bins never wraps at this width
    localparam int SUM_BITS    = COUNT_BITS + LEVEL_BITS;
    localparam int REM_BITS    = SUM_BITS + 1;

    // One quotient bit per divider step: cdf * GRAY_LEVELS / total
    localparam int DIV_STEPS   = LEVEL_BITS;
    localparam int STEP_BITS   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Request codes
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_COUNT = 2'd1,
        REQ_BUILD = 2'd2,
        REQ_MAP   = 2'd3
    } req_code_t;

    // Input beat
    typedef struct packed {
        logic [1:0]          req_type;
        logic [PIX_BITS-1:0] pixel_value;
    } histeq_req_t;

    // Output beat
    typedef struct packed {
        logic [PIX_BITS-1:0] mapped_pixel;
        logic                count_overflow;
    } histeq_res_t;

    // Controller to datapath
    typedef struct packed {
        logic start_item;
        logic clr_hist;
        logic bin_rd_lvl;
        logic bin_rd_idx;
        logic bin_inc;
        logic sum_acc;
        logic cdf_acc;
        logic div_step;
        logic tbl_wr;
        logic tbl_rd;
    } histeq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic idx_last;
    } histeq_stat_t;

endpackage

@@ src/histeq_top.sv @@
// Histogram equalizer for 8-bit pixels. An item is taken when start is high
// and busy is low; busy then stays high until the block can take the next one.
// A count reads and then writes back one bin in the single-port bin memory. In
// a build the bin memory is read once per bin in each of two passes (total,
// then running sum) and each table entry comes from a divider that yields one
// quotient bit per cycle. A map result appears on result with done high for a
// single cycle, in the cycle in which busy falls; it cannot be held off, so
// capture it then. The next item may be started in that same cycle. Maps
// before the first build return unspecified values.
module histogram_equalizer_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  histeq_pkg::histeq_req_t request,
    output logic                    done,
    output histeq_pkg::histeq_res_t result
);

    histeq_pkg::histeq_cmd_t  cmd;
    histeq_pkg::histeq_stat_t stat;

    histeq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd),
        .stat     (stat)
    );

    histeq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_value (request.pixel_value),
        .cmd         (cmd),
        .stat        (stat),
        .result      (result)
    );

    // Every accepted item raises busy and so holds off the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // A map beat's done comes from the MAP_RD state through the done register
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type == histeq_pkg::REQ_MAP) |-> ##2 done)
        else $error("map result missing");

    // Other requests never produce a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type != histeq_pkg::REQ_MAP) |-> ##2 !done)
        else $error("unexpected result beat");

    // Result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

endmodule

@@ src/histeq_ctrl.sv @@
module histeq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               req_type,
    output logic                     busy,
    output logic                     done,
    output histeq_pkg::histeq_cmd_t  cmd,
    input  histeq_pkg::histeq_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_CDF_RD,
        ST_CDF_ACC,
        ST_DIV,
        ST_TBL_WR,
        ST_MAP_RD
    } state_t;

    state_t                                state_reg, state_next;
    logic [histeq_pkg::STEP_BITS-1:0]      step_reg, step_next;
    logic                                  done_reg, done_next;
    logic                                  accept;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign accept = start && !busy;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        histeq_pkg::REQ_CLEAR: state_next = ST_CLEAR;
                        histeq_pkg::REQ_COUNT: state_next = ST_CNT_RD;
                        histeq_pkg::REQ_BUILD: state_next = ST_SUM_RD;
                        default:               state_next = ST_MAP_RD;
                    endcase
                end
            end
            ST_CLEAR:   state_next = ST_IDLE;
            ST_CNT_RD:  state_next = ST_CNT_WR;
            ST_CNT_WR:  state_next = ST_IDLE;
            ST_SUM_RD:  state_next = ST_SUM_ACC;
            ST_SUM_ACC: state_next = stat.idx_last ? ST_CDF_RD : ST_SUM_RD;
            ST_CDF_RD:  state_next = ST_CDF_ACC;
            ST_CDF_ACC:
            begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV:
            begin
                if (step_reg == histeq_pkg::STEP_BITS'(histeq_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_TBL_WR;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_TBL_WR:  state_next = stat.idx_last ? ST_IDLE : ST_CDF_RD;
            ST_MAP_RD:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // State and registered strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Command decode
    always_comb
    begin
        cmd            = '0;
        cmd.start_item = accept;
        cmd.clr_hist   = (state_reg == ST_CLEAR);
        cmd.bin_rd_lvl = (state_reg == ST_CNT_RD);
        cmd.bin_rd_idx = (state_reg == ST_SUM_RD) || (state_reg == ST_CDF_RD);
        cmd.bin_inc    = (state_reg == ST_CNT_WR);
        cmd.sum_acc    = (state_reg == ST_SUM_ACC);
        cmd.cdf_acc    = (state_reg == ST_CDF_ACC);
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.tbl_wr     = (state_reg == ST_TBL_WR);
        cmd.tbl_rd     = (state_reg == ST_MAP_RD);
    end

endmodule

@@ src/histeq_datapath.sv @@
module histeq_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [histeq_pkg::PIX_BITS-1:0] pixel_value,
    input  histeq_pkg::histeq_cmd_t   cmd,
    output histeq_pkg::histeq_stat_t  stat,
    output histeq_pkg::histeq_res_t   result
);

    localparam int LB = histeq_pkg::LEVEL_BITS;
    localparam int CB = histeq_pkg::COUNT_BITS;
    localparam int SB = histeq_pkg::SUM_BITS;
    localparam int RB = histeq_pkg::REM_BITS;
    localparam int PB = histeq_pkg::PIX_BITS;
    localparam int GL = histeq_pkg::GRAY_LEVELS;

    // Memories
    logic [CB-1:0] bin_mem [GL];
    logic [PB-1:0] tbl_mem [GL];

    logic [GL-1:0] bin_vld_reg;
    logic          vld_q_reg;
    logic [CB-1:0] bin_q_reg;
    logic [PB-1:0] tbl_q_reg;
    logic          sat_reg;

    logic [LB-1:0] lvl_reg;
    logic [LB-1:0] idx_reg;
    logic [SB-1:0] total_reg;
    logic [SB-1:0] cdf_reg;
    logic [RB-1:0] rem_reg;
    logic [LB-1:0] quo_reg;

    logic [LB-1:0] level;
    logic [LB-1:0] bin_addr;
    logic [CB-1:0] bin_val;
    logic          bin_full;
    logic          idx_last;
    logic [SB-1:0] cdf_next;
    logic [RB-1:0] rem_dbl;
    logic          rem_ge;
    logic [PB-1:0] tbl_val;

    // Clamp pixel to the top gray level
    always_comb
    begin
        if (32'(pixel_value) > 32'(GL - 1))
        begin
            level = LB'(GL - 1);
        end
        else
        begin
            level = pixel_value[LB-1:0];
        end
    end

    assign bin_addr = cmd.bin_rd_idx ? idx_reg : lvl_reg;
    assign bin_val  = vld_q_reg ? bin_q_reg : '0;
    assign bin_full = (bin_val == {CB{1'b1}});
    assign idx_last = (idx_reg == LB'(GL - 1));
    assign cdf_next = cdf_reg + SB'(bin_val);

    // Restoring divider step
    assign rem_dbl  = {rem_reg[RB-2:0], 1'b0};
    assign rem_ge   = (rem_dbl >= RB'(total_reg));

    // Table entry: empty histogram, top clip, or quotient
    always_comb
    begin
        if (total_reg == '0)
        begin
            tbl_val = '0;
        end
        else if (cdf_reg >= total_reg)
        begin
            tbl_val = PB'(GL - 1);
        end
        else
        begin
            tbl_val = PB'(quo_reg);
        end
    end

    // Bin memory
    always_ff @(posedge clk)
    begin
        if (cmd.bin_rd_lvl || cmd.bin_rd_idx)
        begin
            bin_q_reg <= bin_mem[bin_addr];
        end
        if (cmd.bin_inc && !bin_full)
        begin
            bin_mem[lvl_reg] <= bin_val + 1'b1;
        end
    end

    // Bin valid bits and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg <= '0;
            vld_q_reg   <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clr_hist)
            begin
                bin_vld_reg <= '0;
                sat_reg     <= 1'b0;
            end
            else if (cmd.bin_inc)
            begin
                if (bin_full)
                begin
                    sat_reg <= 1'b1;
                end
                else
                begin
                    bin_vld_reg[lvl_reg] <= 1'b1;
                end
            end
            if (cmd.bin_rd_lvl || cmd.bin_rd_idx)
            begin
                vld_q_reg <= bin_vld_reg[bin_addr];
            end
        end
    end

    // Table memory
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr)
        begin
            tbl_mem[idx_reg] <= tbl_val;
        end
        if (cmd.tbl_rd)
        begin
            tbl_q_reg <= tbl_mem[lvl_reg];
        end
    end

    // Bin walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.start_item)
        begin
            idx_reg <= '0;
        end
        else if (cmd.sum_acc || cmd.tbl_wr)
        begin
            idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
        end
    end

    // Sums and divider
    always_ff @(posedge clk)
    begin
        if (cmd.start_item)
        begin
            lvl_reg   <= level;
            total_reg <= '0;
            cdf_reg   <= '0;
        end
        if (cmd.sum_acc)
        begin
            total_reg <= total_reg + SB'(bin_val);
        end
        if (cmd.cdf_acc)
        begin
            cdf_reg <= cdf_next;
            rem_reg <= RB'(cdf_next);
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_dbl - RB'(total_reg) : rem_dbl;
            quo_reg <= {quo_reg[LB-2:0], rem_ge};
        end
    end

    assign stat.idx_last         = idx_last;
    assign result.mapped_pixel   = tbl_q_reg;
    assign result.count_overflow = sat_reg;

endmodule

@@ sim/histogram_equalizer_top_test.sv @@
module histogram_equalizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import histeq_pkg::*;

    localparam int RANDOM_BEATS = 900;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 50;

    // One row of the directed stimulus; want is used only where typed is set
    typedef struct packed {
        req_code_t           op;
        logic [PIX_BITS-1:0] pix;
        logic                typed;
        logic [PIX_BITS-1:0] want;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    histeq_req_t request;
    histeq_res_t result;

    // Shadow state of the equalizer
    logic [COUNT_BITS-1:0] bin_tally [GRAY_LEVELS];
    logic [PIX_BITS-1:0]   eq_table  [GRAY_LEVELS];
    logic                  hist_saturated;

    histeq_res_t   pending_maps[$];
    directed_row_t directed_rows[26];
    int            fail_count;
    int            burst_left;
    int            random_beats;
    int            idle_cycles;

    histogram_equalizer_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Apply one beat to the shadow state; maps yield the expected result
    task automatic equalize_model(input histeq_req_t beat, output bit makes_result,
                                  output histeq_res_t res);
        int              lvl;
        int              i;
        longint unsigned sum;
        longint unsigned cdf;
        longint unsigned ratio;
        lvl = (int'(beat.pixel_value) > GRAY_LEVELS - 1) ? GRAY_LEVELS - 1
                                                         : int'(beat.pixel_value);
        makes_result = 1'b0;
        res = '0;
        case (req_code_t'(beat.req_type))
            REQ_CLEAR:
            begin
                for (i = 0; i < GRAY_LEVELS; i++)
                    bin_tally[i] = '0;
                hist_saturated = 1'b0;
            end
            REQ_COUNT:
            begin
                // saturating bin
                if (bin_tally[lvl] == {COUNT_BITS{1'b1}})
                    hist_saturated = 1'b1;
                else
                    bin_tally[lvl] = bin_tally[lvl] + 1'b1;
            end
            REQ_BUILD:
            begin
                sum = 0;
                for (i = 0; i < GRAY_LEVELS; i++)
                    sum += bin_tally[i];
                cdf = 0;
                for (i = 0; i < GRAY_LEVELS; i++)
                begin
                    cdf += bin_tally[i];
                    ratio = 0;
                    if (sum != 0)
                    begin
                        ratio = (cdf * GRAY_LEVELS) / sum;
                        // last bins give GRAY_LEVELS, clip instead of wrapping
                        if (ratio > GRAY_LEVELS - 1)
                            ratio = GRAY_LEVELS - 1;
                    end
                    eq_table[i] = ratio[PIX_BITS-1:0];
                end
            end
            default:
            begin
                res.mapped_pixel   = eq_table[lvl];
                res.count_overflow = hist_saturated;
                makes_result = 1'b1;
            end
        endcase
    endtask

    // Offer one beat, sometimes with an idle gap at the start of a burst
    task automatic send_beat(input histeq_req_t beat, input bit typed,
                             input logic [PIX_BITS-1:0] typed_pixel);
        int          gap;
        bit          makes_result;
        histeq_res_t res;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gap = 0;
                19: gap = $urandom_range(10, 40);
                default: gap = $urandom_range(1, 4);
            endcase
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= beat;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        burst_left--;
        equalize_model(beat, makes_result, res);
        if (makes_result)
        begin
            if (typed)
            begin
                res.mapped_pixel   = typed_pixel;
                res.count_overflow = 1'b0;
            end
            pending_maps.push_back(res);
        end
    endtask

    task automatic random_beat(input req_code_t op, input logic [PIX_BITS-1:0] pix);
        histeq_req_t beat;
        beat.req_type    = op;
        beat.pixel_value = pix;
        send_beat(beat, 1'b0, '0);
        random_beats++;
    endtask

    // Pixel drawn around a center, clamped to the 8-bit range
    function automatic logic [PIX_BITS-1:0] pick_pixel(input int center, input int spread);
        int p;
        p = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (p < 0)
            p = 0;
        if (p > 255)
            p = 255;
        return p[PIX_BITS-1:0];
    endfunction

    // Result checker and watchdog
    always @(posedge clk)
    begin
        histeq_res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_maps.size() == 0)
                begin
                    $error("unexpected result beat: mapped_pixel %0d count_overflow %0b",
                           result.mapped_pixel, result.count_overflow);
                    fail_count++;
                end
                else
                begin
                    want = pending_maps.pop_front();
                    if (result.mapped_pixel !== want.mapped_pixel)
                    begin
                        $error("mapped_pixel: expected %0d, got %0d",
                               want.mapped_pixel, result.mapped_pixel);
                        fail_count++;
                    end
                    if (result.count_overflow !== want.count_overflow)
                    begin
                        $error("count_overflow: expected %0b, got %0b",
                               want.count_overflow, result.count_overflow);
                        fail_count++;
                    end
                end
            end
            if ((start && busy === 1'b0) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        int          r;
        int          n;
        int          k;
        int          center;
        int          spread;
        histeq_req_t beat;

        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        fail_count = 0;
        burst_left = 0;
        random_beats = 0;
        idle_cycles = 0;
        beat = '0;
        for (r = 0; r < GRAY_LEVELS; r++)
        begin
            bin_tally[r] = '0;
            eq_table[r] = '0;
        end
        hist_saturated = 1'b0;

        // Empty build, single-pixel histogram, clear keeping the table,
        // top clip on the last bin, then an empty build again
        directed_rows = '{
            '{REQ_BUILD, 8'h00, 1'b0, 8'h00},
            '{REQ_MAP,   8'h00, 1'b1, 8'h00},
            '{REQ_MAP,   8'hFF, 1'b1, 8'h00},
            '{REQ_MAP,   8'hAA, 1'b1, 8'h00},
            '{REQ_COUNT, 8'h00, 1'b0, 8'h00},
            '{REQ_BUILD, 8'h00, 1'b0, 8'h00},
            '{REQ_MAP,   8'h00, 1'b1, 8'hFF},
            '{REQ_MAP,   8'hFF, 1'b1, 8'hFF},
            '{REQ_CLEAR, 8'h00, 1'b0, 8'h00},
            '{REQ_MAP,   8'h55, 1'b1, 8'hFF},
            '{REQ_COUNT, 8'hFF, 1'b0, 8'h00},
            '{REQ_COUNT, 8'hFF, 1'b0, 8'h00},
            '{REQ_COUNT, 8'h00, 1'b0, 8'h00},
            '{REQ_COUNT, 8'h00, 1'b0, 8'h00},
            '{REQ_BUILD, 8'hFF, 1'b0, 8'h00},
            '{REQ_MAP,   8'h00, 1'b1, 8'h80},
            '{REQ_MAP,   8'h7F, 1'b1, 8'h80},
            '{REQ_MAP,   8'hFF, 1'b1, 8'hFF},
            '{REQ_COUNT, 8'h80, 1'b0, 8'h00},
            '{REQ_BUILD, 8'h00, 1'b0, 8'h00},
            '{REQ_MAP,   8'h01, 1'b0, 8'h00},
            '{REQ_MAP,   8'hC8, 1'b0, 8'h00},
            '{REQ_MAP,   8'h80, 1'b0, 8'h00},
            '{REQ_CLEAR, 8'hAA, 1'b0, 8'h00},
            '{REQ_BUILD, 8'h55, 1'b0, 8'h00},
            '{REQ_MAP,   8'h3C, 1'b1, 8'h00}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        for (r = 0; r < $size(directed_rows); r++)
        begin
            beat.req_type    = directed_rows[r].op;
            beat.pixel_value = directed_rows[r].pix;
            send_beat(beat, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random part: mostly clear / count / build / map frames, some noise
        while (random_beats < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 99) < 85)
                    random_beat(REQ_CLEAR, PIX_BITS'($urandom_range(0, 255)));
                center = $urandom_range(0, 255);
                case ($urandom_range(0, 3))
                    0: spread = 0;
                    1: spread = 4;
                    2: spread = 32;
                    default: spread = 128;
                endcase
                n = $urandom_range(1, 40);
                for (k = 0; k < n; k++)
                    random_beat(REQ_COUNT, pick_pixel(center, spread));
                random_beat(REQ_BUILD, PIX_BITS'($urandom_range(0, 255)));
                n = $urandom_range(4, 30);
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 1) == 0)
                        random_beat(REQ_MAP, pick_pixel(center, spread + 2));
                    else
                        random_beat(REQ_MAP, PIX_BITS'($urandom_range(0, 255)));
                end
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    random_beat(req_code_t'($urandom_range(0, 3)),
                                PIX_BITS'($urandom_range(0, 255)));
            end
        end
        start <= 1'b0;

        // Drain, then let the block settle
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_maps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
